// File: sv/prefix_rectangle_mean_macros.svh
// Assertion macros used by the block's controller.
`ifndef PREFIX_RECTANGLE_MEAN_MACROS_SVH
`define PREFIX_RECTANGLE_MEAN_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define PRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/prm_pkg.sv
package prm_pkg;

  localparam int MaxCols       = 64;
  localparam int MaxRows       = 64;
  localparam int ElementBits   = 16;
  localparam int RowLengthBits = 7;

  localparam logic [RowLengthBits-1:0] RowLengthReset = RowLengthBits'(1);

  typedef struct packed {
    logic accept;
    logic sum_load;
    logic div_step;
    logic out_load;
  } prm_cmd_t;

  typedef struct packed {
    logic div_last;
  } prm_status_t;

endpackage

// File: sv/prm_in_if.sv
interface prm_in_if #(
  parameter int EB = prm_pkg::ElementBits
);
  logic                 valid;
  logic                 ready;
  logic signed [EB-1:0] element;
  logic                 first;

  modport source (output valid, output element, output first, input ready);
  modport sink   (input valid, input element, input first, output ready);
endinterface

// File: sv/prm_out_if.sv
interface prm_out_if #(
  parameter int EB = prm_pkg::ElementBits
);
  logic                 valid;
  logic                 ready;
  logic signed [EB-1:0] mean;
  logic                 row_end;
  logic                 overflow;

  modport source (output valid, output mean, output row_end, output overflow, input ready);
  modport sink   (input valid, input mean, input row_end, input overflow, output ready);
endinterface

// File: sv/prefix_rectangle_mean.sv
// Running top-left rectangle mean of a signed matrix streamed in raster order.
// Each accepted item yields one result: the mean of all elements from (0,0) to
// the item's position, truncated toward zero, plus a row-end mark and an
// overflow mark once the row count reaches MAX_ROWS (mean then reads 0). A set
// first field starts a new matrix. Prefix sums of the previous row sit in a
// MAX_COLS-entry RAM. Each accepted item is registered, its rectangle sum is
// loaded into a restoring divider that retires one quotient bit per cycle over
// SW = ELEMENT_BITS + clog2(MAX_COLS*MAX_ROWS) bits, and the quotient is then
// loaded into the output register; one item is in flight at a time, so the next
// item is taken only after that load. A finished result waits in the output
// register while the next item is taken; a result that is still not taken when
// the next one finishes holds the block until it is. Write
// row_length only while idle; a row made longer inside a matrix reads prefix
// entries that may never have been written.
module prefix_rectangle_mean #(
  parameter int MAX_COLS     = prm_pkg::MaxCols,
  parameter int MAX_ROWS     = prm_pkg::MaxRows,
  parameter int ELEMENT_BITS = prm_pkg::ElementBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prm_pkg::RowLengthBits-1:0] cfg_wdata_i,
  prm_in_if.sink                            in_i,
  prm_out_if.source                         out_o
);
  import prm_pkg::*;

  prm_cmd_t    cmd;
  prm_status_t status;

  prm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  prm_datapath #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .element_i   (in_i.element),
    .first_i     (in_i.first),
    .cmd_i       (cmd),
    .status_o    (status),
    .mean_o      (out_o.mean),
    .row_end_o   (out_o.row_end),
    .overflow_o  (out_o.overflow)
  );

endmodule

// File: sv/prm_ram.sv
module prm_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/prm_datapath.sv
module prm_datapath #(
  parameter int MAX_COLS     = prm_pkg::MaxCols,
  parameter int MAX_ROWS     = prm_pkg::MaxRows,
  parameter int ELEMENT_BITS = prm_pkg::ElementBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [prm_pkg::RowLengthBits-1:0]    cfg_wdata_i,
  input  logic signed [ELEMENT_BITS-1:0]       element_i,
  input  logic                                 first_i,
  input  prm_pkg::prm_cmd_t                    cmd_i,
  output prm_pkg::prm_status_t                 status_o,
  output logic signed [ELEMENT_BITS-1:0]       mean_o,
  output logic                                 row_end_o,
  output logic                                 overflow_o
);
  import prm_pkg::*;

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW  = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int RSW = ELEMENT_BITS + $clog2(MAX_COLS);
  localparam int SW  = ELEMENT_BITS + $clog2(MAX_COLS * MAX_ROWS);
  localparam int NW  = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int DCW = $clog2(SW + 1);

  // configuration
  logic [RowLengthBits-1:0] row_length_q;
  logic [LW-1:0]            len;

  // position state
  logic [CW-1:0]         col_q;
  logic [RW-1:0]         row_q;
  logic signed [RSW-1:0] run_q;

  // current item, combinational at accept
  logic [CW-1:0]         col_base, col_cur;
  logic [RW-1:0]         row_base;
  logic signed [RSW-1:0] elem_ext, run_cur;
  logic                  over_cur, last_cur;

  // item registers
  logic [CW-1:0]         icol_q;
  logic [RW-1:0]         irow_q;
  logic signed [RSW-1:0] irun_q;
  logic                  iover_q, ilast_q;

  // rectangle sum and divisor
  logic [SW-1:0]         rdata;
  logic signed [SW-1:0]  above, total;
  logic [RW:0]           rp1;
  logic [CW:0]           cp1;
  logic [RW+CW+1:0]      prod;

  // divider
  logic [SW-1:0]  quot_q, quot_neg;
  logic [NW-1:0]  rem_q, dvsr_q;
  logic           neg_q;
  logic [DCW-1:0] dcnt_q;
  logic [NW:0]    shifted;
  logic [NW+1:0]  trial;

  // result
  logic signed [ELEMENT_BITS-1:0] mean_q;
  logic                           row_end_q, overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= RowLengthReset;
    end else if (cfg_we_i) begin
      row_length_q <= cfg_wdata_i;
    end
  end

  // zero length counts as one, oversize saturates
  always_comb begin
    if (row_length_q == '0) begin
      len = LW'(1);
    end else if (32'(row_length_q) > 32'(MAX_COLS)) begin
      len = LW'(MAX_COLS);
    end else begin
      len = LW'(row_length_q);
    end
  end

  always_comb begin
    col_base = first_i ? '0 : col_q;
    row_base = first_i ? '0 : row_q;
    // a shortened row ends at its new last column
    if (32'(col_base) >= 32'(len)) begin
      col_cur = CW'(len - LW'(1));
    end else begin
      col_cur = col_base;
    end
    elem_ext = RSW'(element_i);
    run_cur  = (col_cur == '0) ? elem_ext : run_q + elem_ext;
    over_cur = 32'(row_base) >= 32'(MAX_ROWS);
    last_cur = (32'(col_cur) + 32'd1) >= 32'(len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      run_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= last_cur ? '0 : CW'(col_cur + CW'(1));
      row_q <= (last_cur && !over_cur) ? RW'(row_base + RW'(1)) : row_base;
      run_q <= run_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      icol_q  <= col_cur;
      irow_q  <= row_base;
      irun_q  <= run_cur;
      iover_q <= over_cur;
      ilast_q <= last_cur;
    end
  end

  // first row has nothing above it
  always_comb begin
    above = (irow_q != '0) ? signed'(rdata) : '0;
    total = SW'(irun_q) + above;
    rp1   = {1'b0, irow_q} + (RW+1)'(1);
    cp1   = {1'b0, icol_q} + (CW+1)'(1);
    prod  = (RW+CW+2)'(rp1) * (RW+CW+2)'(cp1);
  end

  prm_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sum_load && !iover_q),
    .waddr_i (icol_q),
    .wdata_i (total),
    .re_i    (cmd_i.accept),
    .raddr_i (col_cur),
    .rdata_o (rdata)
  );

  // restoring division on the magnitude, one quotient bit per step
  always_comb begin
    shifted = {rem_q, quot_q[SW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.sum_load) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_load) begin
      quot_q <= total[SW-1] ? SW'(-total) : SW'(total);
      rem_q  <= '0;
      dvsr_q <= NW'(prod);
      neg_q  <= total[SW-1];
    end else if (cmd_i.div_step) begin
      if (!trial[NW+1]) begin
        rem_q  <= NW'(trial);
        quot_q <= {quot_q[SW-2:0], 1'b1};
      end else begin
        rem_q  <= NW'(shifted);
        quot_q <= {quot_q[SW-2:0], 1'b0};
      end
    end
  end

  assign status_o.div_last = (dcnt_q == DCW'(SW - 1));
  assign quot_neg          = -quot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (iover_q) begin
        mean_q <= '0;
      end else if (neg_q) begin
        mean_q <= ELEMENT_BITS'(quot_neg);
      end else begin
        mean_q <= ELEMENT_BITS'(quot_q);
      end
      row_end_q  <= ilast_q;
      overflow_q <= iover_q;
    end
  end

  assign mean_o     = mean_q;
  assign row_end_o  = row_end_q;
  assign overflow_o = overflow_q;

endmodule

// File: sv/prm_ctrl.sv
`include "prefix_rectangle_mean_macros.svh"

module prm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  prm_pkg::prm_status_t status_i,
  output prm_pkg::prm_cmd_t    cmd_o
);
  import prm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSum  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StSum;
        end
      end
      StSum: begin
        cmd_o.sum_load = 1'b1;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        // hold until the output slot frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PRM_ASSERT_NEXT(a_accept_then_sum, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == StSum, "accepted item did not move to sum")
  `PRM_ASSERT_NOW(a_load_into_free_slot, clk_i, rst_ni, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwrote an untaken result")
  `PRM_ASSERT_NEXT(a_last_step_finishes, clk_i, rst_ni, cmd_o.div_step && status_i.div_last, state_q == StFin, "division did not finish after last step")

endmodule
